// ----- design/flow_byte_counter_top_n_core_defines.svh -----
// Assertion macros for the flow byte counter.
`ifndef FLOW_BYTE_COUNTER_TOP_N_CORE_DEFINES_SVH
`define FLOW_BYTE_COUNTER_TOP_N_CORE_DEFINES_SVH

// Clocked check, held off while in reset.
`define FBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/fbc_pkg.sv -----
// Shared constants and types of the flow byte counter.
`default_nettype none
package fbc_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_REPORT  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int TOTAL_W     = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } state_t;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Rank of the result handed out last; the next one must sort after it.
    typedef struct packed {
        logic                 first;
        logic [TOTAL_W-1:0]   total;
        logic [IDX_W-1:0]     idx;
    } rank_prev_t;
endpackage
`default_nettype wire

// ----- design/fbc_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- design/fbc_rank.sv -----
// Ranking step of the top-N selection: does a candidate slot replace the best so far.
`default_nettype none
module fbc_rank (
    input  wire fbc_pkg::rank_prev_t              prev,
    input  wire logic                             found,
    input  wire logic [fbc_pkg::TOTAL_W-1:0]      best_total,
    input  wire logic [fbc_pkg::IDX_W-1:0]        cand_idx,
    input  wire logic [fbc_pkg::TOTAL_W-1:0]      cand_total,
    output logic                                  take
);
    logic eligible;

    // order is total descending, then slot ascending
    always_comb begin
        eligible = prev.first || (cand_total < prev.total) ||
                   ((cand_total == prev.total) && (cand_idx > prev.idx));
        // slots arrive in ascending order, so strict > keeps the lower slot on a tie
        take = eligible && (!found || (cand_total > best_total));
    end
endmodule
`default_nettype wire

// ----- design/flow_byte_counter_top_n_core.sv -----
// Top level of the flow byte counter with top-N report.
//
// Input channel s_*: one request per item. s_kind 0 records s_packet_bytes against the
// flow (s_src_addr, s_dst_addr); s_kind 1 asks for the s_report_count largest flows.
// Result channel m_*: report results only, largest total first, m_last on the final
// one; an empty table gives one result with m_table_empty set and all else zero.
// Flows occupy slots 0..used-1 in order of arrival, so a lookup walks the used slots
// through the key and total RAMs, one read a cycle, each read registered.
// A record walks the used slots (scan) and then writes back (write-back) before the next
// s_ready, also when the table is empty.
// A report makes one full table walk per result before m_valid; an empty report shows
// its result in the cycle after acceptance.
// One request is in flight at a time: s_ready is high only while idle.
// A stalled result holds in the output registers until m_ready; the walk for the next
// result starts after it is taken.
// Reset empties the table at once through the fill count; no clearing pass is needed.
// A record of a new flow into a full table is dropped.
`default_nettype none
`include "flow_byte_counter_top_n_core_defines.svh"
module flow_byte_counter_top_n_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_src_addr,
    input  wire logic [31:0] s_dst_addr,
    input  wire logic [15:0] s_packet_bytes,
    input  wire logic [4:0]  s_report_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_flow_src,
    output logic [31:0]      m_flow_dst,
    output logic [63:0]      m_flow_total,
    output logic             m_last,
    output logic             m_table_empty
);
    localparam int IDX_W   = fbc_pkg::IDX_W;
    localparam int CNT_W   = fbc_pkg::CNT_W;
    localparam int KEY_W   = fbc_pkg::KEY_W;
    localparam int TOTAL_W = fbc_pkg::TOTAL_W;

    fbc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic               rd_valid_reg, rd_valid_next;

    logic               kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [15:0]        bytes_reg, bytes_next;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [TOTAL_W-1:0] best_total_reg, best_total_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    fbc_pkg::rank_prev_t prev_reg, prev_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [31:0]        out_src_reg, out_src_next;
    logic [31:0]        out_dst_reg, out_dst_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic               key_we, total_we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [TOTAL_W-1:0] total_wdata;
    logic [KEY_W-1:0]   key_rd;
    logic [TOTAL_W-1:0] total_rd;
    logic               take;
    logic [31:0]        want;

    fbc_ram #(.WIDTH(KEY_W), .DEPTH(fbc_pkg::TABLE_DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rd)
    );

    fbc_ram #(.WIDTH(TOTAL_W), .DEPTH(fbc_pkg::TABLE_DEPTH)) u_total_ram (
        .aclk  (aclk),
        .we    (total_we),
        .waddr (waddr),
        .wdata (total_wdata),
        .raddr (raddr),
        .rdata (total_rd)
    );

    fbc_rank u_rank (
        .prev       (prev_reg),
        .found      (found_reg),
        .best_total (best_total_reg),
        .cand_idx   (rd_idx_reg),
        .cand_total (total_rd),
        .take       (take)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fbc_pkg::ST_IDLE;
            used_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        bytes_reg      <= bytes_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_total_reg <= best_total_next;
        best_key_reg   <= best_key_next;
        prev_reg       <= prev_next;
        rem_reg        <= rem_next;
        out_src_reg    <= out_src_next;
        out_dst_reg    <= out_dst_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        rd_valid_next   = 1'b0;
        kind_next       = kind_reg;
        key_next        = key_reg;
        bytes_next      = bytes_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_total_next = best_total_reg;
        best_key_next   = best_key_reg;
        prev_next       = prev_reg;
        rem_next        = rem_reg;
        out_src_next    = out_src_reg;
        out_dst_next    = out_dst_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        key_we          = 1'b0;
        total_we        = 1'b0;
        waddr           = best_idx_reg;
        raddr           = addr_reg[IDX_W-1:0];
        total_wdata     = best_total_reg + {{(TOTAL_W-16){1'b0}}, bytes_reg};
        s_ready         = 1'b0;
        m_valid         = 1'b0;

        want = 32'(s_report_count);
        if (want == 32'd0) begin
            want = 32'd1;
        end
        if (want > 32'(fbc_pkg::MAX_REPORT)) begin
            want = 32'(fbc_pkg::MAX_REPORT);
        end
        if (want > 32'(used_reg)) begin
            want = 32'(used_reg);
        end

        unique case (state_reg)
            fbc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next      = s_kind;
                    key_next       = {s_src_addr, s_dst_addr};
                    bytes_next     = s_packet_bytes;
                    addr_next      = '0;
                    found_next     = 1'b0;
                    prev_next.first = 1'b1;
                    if (s_kind == fbc_pkg::KIND_RECORD) begin
                        state_next = fbc_pkg::ST_SCAN;
                    end else if (used_reg == '0) begin
                        out_src_next   = '0;
                        out_dst_next   = '0;
                        out_total_next = '0;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b1;
                        rem_next       = '0;
                        state_next     = fbc_pkg::ST_EMIT;
                    end else begin
                        rem_next   = want[CNT_W-1:0];
                        state_next = fbc_pkg::ST_SCAN;
                    end
                end
            end
            fbc_pkg::ST_SCAN: begin
                if (addr_reg != used_reg) begin
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = addr_reg[IDX_W-1:0];
                end
                if (rd_valid_reg) begin
                    if (kind_reg == fbc_pkg::KIND_RECORD) begin
                        if (key_rd == key_reg) begin
                            found_next      = 1'b1;
                            best_idx_next   = rd_idx_reg;
                            best_total_next = total_rd;
                        end
                    end else if (take) begin
                        found_next      = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_total_next = total_rd;
                        best_key_next   = key_rd;
                    end
                end else if (addr_reg == used_reg) begin
                    if (kind_reg == fbc_pkg::KIND_RECORD) begin
                        state_next = fbc_pkg::ST_WRITE;
                    end else begin
                        out_src_next   = best_key_reg[KEY_W-1:32];
                        out_dst_next   = best_key_reg[31:0];
                        out_total_next = best_total_reg;
                        out_last_next  = (rem_reg == CNT_W'(1));
                        out_empty_next = 1'b0;
                        rem_next       = rem_reg - 1'b1;
                        state_next     = fbc_pkg::ST_EMIT;
                    end
                end
            end
            fbc_pkg::ST_WRITE: begin
                if (found_reg) begin
                    total_we = 1'b1;
                end else if (used_reg != CNT_W'(fbc_pkg::TABLE_DEPTH)) begin
                    // new flow takes the next free slot
                    waddr       = used_reg[IDX_W-1:0];
                    total_wdata = {{(TOTAL_W-16){1'b0}}, bytes_reg};
                    key_we      = 1'b1;
                    total_we    = 1'b1;
                    used_next   = used_reg + 1'b1;
                end
                state_next = fbc_pkg::ST_IDLE;
            end
            fbc_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (rem_reg == '0) begin
                        state_next = fbc_pkg::ST_IDLE;
                    end else begin
                        prev_next.first = 1'b0;
                        prev_next.total = best_total_reg;
                        prev_next.idx   = best_idx_reg;
                        addr_next       = '0;
                        found_next      = 1'b0;
                        state_next      = fbc_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = fbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_flow_src    = out_src_reg;
    assign m_flow_dst    = out_dst_reg;
    assign m_flow_total  = out_total_reg;
    assign m_last        = out_last_reg;
    assign m_table_empty = out_empty_reg;

    `FBC_ASSERT(a_one_side, !(s_ready && m_valid), "accept and result overlap")
    `FBC_ASSERT(a_used_range, used_reg <= CNT_W'(fbc_pkg::TABLE_DEPTH), "fill count overflow")
    `FBC_ASSERT(a_empty_alone, (m_valid && m_table_empty) |-> (!m_last && m_flow_total == '0), "empty result carries data")
    `FBC_ASSERT(a_write_once, (state_reg == fbc_pkg::ST_WRITE) |=> (state_reg == fbc_pkg::ST_IDLE), "write-back not single cycle")
    `FBC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> state_reg == fbc_pkg::ST_IDLE, "not idle after reset")
endmodule
`default_nettype wire
